// File: design/gas_resistance_aqi_estimator_top_assert.svh
// Assertion macros shared by the estimator modules.
`ifndef GAS_RESISTANCE_AQI_ESTIMATOR_TOP_ASSERT_SVH
`define GAS_RESISTANCE_AQI_ESTIMATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GRAQ_ASSERT_SAME(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GRAQ_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/graq_pkg.sv
package graq_pkg;

  localparam int RES_W       = 24;
  localparam int INDEX_W     = 17;
  localparam int SLOPE_W     = 16;
  localparam int ALPHA_W     = 9;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int AVG_SHIFT   = 8;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  localparam logic [CFG_INDEX_W-1:0] REG_REF_RESISTANCE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REF_INDEX      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOPE          = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_RESISTANCE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_MAX      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA          = 3'd5;

  localparam logic [RES_W-1:0]   RST_REF_RESISTANCE = 24'd43000;
  localparam logic [INDEX_W-1:0] RST_REF_INDEX      = 17'd10496;
  localparam logic [SLOPE_W-1:0] RST_SLOPE          = 16'd11867;
  localparam logic [RES_W-1:0]   RST_MIN_RESISTANCE = 24'd100;
  localparam logic [INDEX_W-1:0] RST_INDEX_MAX      = 17'd128000;
  localparam logic [ALPHA_W-1:0] RST_ALPHA          = 9'd26;

  typedef struct packed {
    logic [RES_W-1:0] gas_resistance_ohm;
  } reading_t;

  typedef struct packed {
    logic [INDEX_W-1:0] smoothed_index_q8;
    logic [INDEX_W-1:0] instant_index_q8;
    logic               first_reading;
  } result_t;

  typedef struct packed {
    logic load;
    logic norm;
    logic calc_log;
    logic mul;
    logic inst;
    logic avg_mul;
    logic publish;
  } graq_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic out_free;
  } graq_status_t;

endpackage

// File: design/graq_reading_if.sv
interface graq_reading_if;
  import graq_pkg::*;

  logic     valid;
  logic     ready;
  reading_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/graq_result_if.sv
interface graq_result_if;
  import graq_pkg::*;

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/graq_ctrl.sv
module graq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  reading_valid,
  output logic                  reading_ready,
  input  graq_pkg::graq_status_t status,
  output graq_pkg::graq_cmd_t   cmd
);
  import graq_pkg::*;

  `include "gas_resistance_aqi_estimator_top_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_LOG,
    S_MUL,
    S_INST,
    S_AVG_MUL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    reading_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        reading_ready = 1'b1;
        if (reading_valid) begin
          cmd.load = 1'b1;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (status.norm_done) begin
          state_next = S_LOG;
        end
      end
      S_LOG: begin
        cmd.calc_log = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_INST;
      end
      S_INST: begin
        cmd.inst = 1'b1;
        state_next = S_AVG_MUL;
      end
      S_AVG_MUL: begin
        cmd.avg_mul = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `GRAQ_ASSERT_NEXT(a_accept_starts_norm, clk, rst, reading_valid && reading_ready,
                    state == S_NORM, "accepted beat did not start normalization")
  `GRAQ_ASSERT_SAME(a_publish_when_free, clk, rst, cmd.publish, status.out_free,
                    "result published into a full output register")
  `GRAQ_ASSERT_NEXT(a_done_holds, clk, rst, state == S_DONE && !status.out_free,
                    state == S_DONE, "finished result dropped while output stalled")

endmodule

// File: design/graq_datapath.sv
module graq_datapath #(
  parameter int LOG_FRAC_BITS  = 8,
  parameter int LOG_TABLE_BITS = 6,
  parameter int RES_BITS       = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [graq_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [graq_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  graq_pkg::reading_t                     reading_payload,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output graq_pkg::result_t                      result_payload,
  input  graq_pkg::graq_cmd_t                    cmd,
  output graq_pkg::graq_status_t                 status
);
  import graq_pkg::*;

  `include "gas_resistance_aqi_estimator_top_assert.svh"

  localparam int PW      = $clog2(RES_W);
  localparam int LOG_W   = PW + LOG_FRAC_BITS;
  localparam int DIFF_W  = LOG_W + 1;
  localparam int PROD_W  = SLOPE_W + 1 + DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int TAB_N   = 1 << LOG_TABLE_BITS;
  localparam int TAB_W   = TAB_N * LOG_FRAC_BITS;
  localparam int D_W     = INDEX_W + 1;
  localparam int APROD_W = ALPHA_W + 1 + D_W;

  localparam logic [RES_W-1:0] RES_TOP = (RES_BITS >= RES_W) ? {RES_W{1'b1}} :
                                         RES_W'((64'd1 << RES_BITS) - 64'd1);
  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (LOG_FRAC_BITS - 1);
  localparam logic [APROD_W-1:0] AVG_HALF = APROD_W'(1) << (AVG_SHIFT - 1);

  // Each entry is log2(1 + i/TAB_N), found by repeated squaring of the mantissa in Q30.
  function automatic logic [TAB_W-1:0] build_log_table();
    logic [TAB_W-1:0]         tab;
    logic [63:0]              v;
    logic [LOG_FRAC_BITS-1:0] r;
    tab = '0;
    for (int i = 0; i < TAB_N; i++) begin
      v = 64'(TAB_N + i) << (30 - LOG_TABLE_BITS);
      r = '0;
      for (int k = 0; k < LOG_FRAC_BITS; k++) begin
        v = (v * v) >> 30;
        r = r << 1;
        if (v >= (64'd1 << 31)) begin
          r[0] = 1'b1;
          v = v >> 1;
        end
      end
      tab[i*LOG_FRAC_BITS +: LOG_FRAC_BITS] = r;
    end
    return tab;
  endfunction

  localparam logic [TAB_W-1:0] LOG_TAB = build_log_table();

  logic [RES_W-1:0]   ref_resistance;
  logic [INDEX_W-1:0] ref_index;
  logic [SLOPE_W-1:0] slope;
  logic [RES_W-1:0]   min_resistance;
  logic [INDEX_W-1:0] index_max;
  logic [ALPHA_W-1:0] alpha;

  logic [INDEX_W-1:0] avg;
  logic               avg_valid;

  logic [RES_W-1:0]          x_ref;
  logic [RES_W-1:0]          x_rd;
  logic [PW-1:0]             p_ref;
  logic [PW-1:0]             p_rd;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic [INDEX_W-1:0]        inst;
  logic signed [APROD_W-1:0] aprod;

  logic [RES_W-1:0]          rd_sat;
  logic [RES_W-1:0]          mn_sat;
  logic [RES_W-1:0]          rf_sat;
  logic [RES_W-1:0]          rd_lift;
  logic [LOG_TABLE_BITS-1:0] tidx_ref;
  logic [LOG_TABLE_BITS-1:0] tidx_rd;
  logic [LOG_W-1:0]          log_ref;
  logic [LOG_W-1:0]          log_rd;
  logic [PROD_W-1:0]         mag;
  logic [PROD_W-1:0]         q;
  logic signed [PROD_W-1:0]  sq;
  logic signed [SUM_W-1:0]   sum;
  logic [INDEX_W-1:0]        inst_next;
  logic [ALPHA_W-1:0]        alpha_eff;
  logic signed [D_W-1:0]     d;
  logic [APROD_W-1:0]        amag;
  logic [APROD_W-1:0]        aq;
  logic [INDEX_W-1:0]        avg_next;
  logic                      first_next;

  always_comb begin
    rd_sat = (reading_payload.gas_resistance_ohm > RES_TOP) ? RES_TOP :
             reading_payload.gas_resistance_ohm;
    mn_sat = (min_resistance > RES_TOP) ? RES_TOP : min_resistance;
    rf_sat = (ref_resistance > RES_TOP) ? RES_TOP : ref_resistance;
    rd_lift = (rd_sat < mn_sat) ? mn_sat : rd_sat;
    if (rd_lift == '0) begin
      rd_lift = RES_W'(1);
    end
    if (rf_sat == '0) begin
      rf_sat = RES_W'(1);
    end
  end

  always_comb begin
    tidx_ref = x_ref[RES_W-2 -: LOG_TABLE_BITS];
    tidx_rd  = x_rd[RES_W-2 -: LOG_TABLE_BITS];
    log_ref  = {p_ref, LOG_TAB[tidx_ref*LOG_FRAC_BITS +: LOG_FRAC_BITS]};
    log_rd   = {p_rd, LOG_TAB[tidx_rd*LOG_FRAC_BITS +: LOG_FRAC_BITS]};
  end

  // Round the scaled slope product to nearest, ties away from zero, then clamp.
  always_comb begin
    mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    q = (mag + HALF_LSB) >> LOG_FRAC_BITS;
    sq = prod[PROD_W-1] ? -$signed(q) : $signed(q);
    sum = $signed(SUM_W'(ref_index)) + SUM_W'(sq);
    if (sum < 0) begin
      inst_next = '0;
    end else if (sum > $signed(SUM_W'(index_max))) begin
      inst_next = index_max;
    end else begin
      inst_next = sum[INDEX_W-1:0];
    end
  end

  always_comb begin
    alpha_eff = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
    d = $signed({1'b0, inst}) - $signed({1'b0, avg});
    amag = aprod[APROD_W-1] ? APROD_W'(-aprod) : APROD_W'(aprod);
    aq = (amag + AVG_HALF) >> AVG_SHIFT;
    first_next = !avg_valid;
    if (!avg_valid) begin
      avg_next = inst;
    end else if (aprod[APROD_W-1]) begin
      avg_next = avg - aq[INDEX_W-1:0];
    end else begin
      avg_next = avg + aq[INDEX_W-1:0];
    end
  end

  always_comb begin
    status.norm_done = x_ref[RES_W-1] && x_rd[RES_W-1];
    status.out_free  = !result_valid || result_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_resistance <= RST_REF_RESISTANCE;
      ref_index      <= RST_REF_INDEX;
      slope          <= RST_SLOPE;
      min_resistance <= RST_MIN_RESISTANCE;
      index_max      <= RST_INDEX_MAX;
      alpha          <= RST_ALPHA;
      avg            <= '0;
      avg_valid      <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_REF_RESISTANCE: ref_resistance <= cfg_data[RES_W-1:0];
          REG_REF_INDEX:      ref_index      <= cfg_data[INDEX_W-1:0];
          REG_SLOPE:          slope          <= cfg_data[SLOPE_W-1:0];
          REG_MIN_RESISTANCE: min_resistance <= cfg_data[RES_W-1:0];
          REG_INDEX_MAX:      index_max      <= cfg_data[INDEX_W-1:0];
          REG_ALPHA:          alpha          <= cfg_data[ALPHA_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.publish) begin
        avg          <= avg_next;
        avg_valid    <= 1'b1;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_ref <= rf_sat;
      x_rd  <= rd_lift;
      p_ref <= PW'(RES_W - 1);
      p_rd  <= PW'(RES_W - 1);
    end
    if (cmd.norm) begin
      if (!x_ref[RES_W-1]) begin
        x_ref <= x_ref << 1;
        p_ref <= p_ref - PW'(1);
      end
      if (!x_rd[RES_W-1]) begin
        x_rd <= x_rd << 1;
        p_rd <= p_rd - PW'(1);
      end
    end
    if (cmd.calc_log) begin
      diff <= $signed({1'b0, log_ref}) - $signed({1'b0, log_rd});
    end
    if (cmd.mul) begin
      prod <= $signed(PROD_W'(slope)) * PROD_W'(diff);
    end
    if (cmd.inst) begin
      inst <= inst_next;
    end
    if (cmd.avg_mul) begin
      aprod <= $signed(APROD_W'(alpha_eff)) * APROD_W'(d);
    end
    if (cmd.publish) begin
      result_payload.smoothed_index_q8 <= avg_next;
      result_payload.instant_index_q8  <= inst;
      result_payload.first_reading     <= first_next;
    end
  end

  `GRAQ_ASSERT_NEXT(a_load_nonzero, clk, rst, cmd.load, (x_ref != '0) && (x_rd != '0),
                    "log operand is zero after load")
  `GRAQ_ASSERT_NEXT(a_publish_valid, clk, rst, cmd.publish, result_valid && avg_valid,
                    "published result not presented")

endmodule

// File: design/gas_resistance_aqi_estimator_top.sv
// Channel  Dir  Beat payload
// reading  in   gas_resistance_ohm
// result   out  smoothed_index_q8, instant_index_q8, first_reading
//
// A new reading is taken only while the block is idle, after the previous result has been
// published; the wait for its result grows with L (0 to 23), the larger leading-zero count of
// the reference and the clamped reading in 24 bits, which the shared one-bit-per-cycle
// normalizer shifts out of both operands.
// Synchronous rst restores the register defaults and forgets the running average.
// A finished result waits in the output register; the next reading is taken meanwhile,
// and its result waits until the register has been emptied.
module gas_resistance_aqi_estimator_top #(
  parameter int LOG_FRAC_BITS  = 8,
  parameter int LOG_TABLE_BITS = 6,
  parameter int RES_BITS       = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  graq_reading_if.sink                     reading,
  graq_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [graq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [graq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import graq_pkg::*;

  graq_cmd_t    cmd;
  graq_status_t status;
  logic         reading_ready;
  logic         result_valid;
  result_t      result_payload;

  graq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .reading_valid (reading.valid),
    .reading_ready (reading_ready),
    .status        (status),
    .cmd           (cmd)
  );

  graq_datapath #(
    .LOG_FRAC_BITS  (LOG_FRAC_BITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS),
    .RES_BITS       (RES_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .reading_payload (reading.payload),
    .result_valid    (result_valid),
    .result_ready    (result.ready),
    .result_payload  (result_payload),
    .cmd             (cmd),
    .status          (status)
  );

  assign reading.ready  = reading_ready;
  assign result.valid   = result_valid;
  assign result.payload = result_payload;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import graq_pkg::*;

  localparam int FRAC_BITS   = 8;
  localparam int TABLE_BITS  = 6;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [RES_W-1:0]       OHM_TOP      = '1;
  localparam logic [INDEX_W-1:0]     INDEX_TOP    = 17'd128000;
  localparam logic [SLOPE_W-1:0]     SLOPE_TOP    = '1;
  localparam logic [ALPHA_W-1:0]     ALPHA_OVER   = '1;

  typedef enum logic {ROW_READING, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                  typed;
    result_t               value;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  graq_reading_if reading_ch ();
  graq_result_if  result_ch ();

  gas_resistance_aqi_estimator_top dut (
    .clk       (clk),
    .rst       (rst),
    .reading   (reading_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers and the running average.
  logic [RES_W-1:0]   ref_ohm;
  logic [INDEX_W-1:0] ref_index;
  logic [SLOPE_W-1:0] slope;
  logic [RES_W-1:0]   floor_ohm;
  logic [INDEX_W-1:0] index_max;
  logic [ALPHA_W-1:0] alpha;
  logic [INDEX_W-1:0] avg;
  logic               avg_loaded;

  result_t   awaited_aqi [$];
  plan_row_t sent_rows [$];
  plan_row_t plan [$];
  int        bad_beats;
  int        quiet_cycles;
  bit        src_eager;
  bit        force_eager;
  bit        hold_request;
  int        src_beats;

  function automatic longint round_half_away(longint v, int sh);
    longint unsigned mag;
    longint unsigned q;
    mag = (v < 0) ? -v : v;
    q = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Leading-one position as the integer part, the fraction from repeated squaring.
  function automatic int log2_q8(logic [RES_W-1:0] x);
    logic [RES_W-1:0] v;
    logic [63:0] wide;
    logic [63:0] m;
    int lead;
    int b;
    int k;
    int part;
    int frac;
    v = (x == 0) ? RES_W'(1) : x;
    lead = 0;
    for (b = 0; b < RES_W; b++) if (v[b]) lead = b;
    wide = 64'(v);
    part = int'(((wide << TABLE_BITS) >> lead) & ((64'd1 << TABLE_BITS) - 1));
    m = 64'((1 << TABLE_BITS) + part) << (30 - TABLE_BITS);
    frac = 0;
    for (k = 0; k < FRAC_BITS; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (lead << FRAC_BITS) + frac;
  endfunction

  function automatic result_t estimate_aqi(logic [RES_W-1:0] ohm);
    logic [RES_W-1:0] r;
    logic [RES_W-1:0] rf;
    longint log_gap;
    longint idx;
    longint d;
    int unsigned a;
    result_t est;
    r = (ohm < floor_ohm) ? floor_ohm : ohm;
    if (r == 0) r = RES_W'(1);
    rf = (ref_ohm == 0) ? RES_W'(1) : ref_ohm;
    log_gap = longint'(log2_q8(rf)) - longint'(log2_q8(r));
    idx = longint'(ref_index) + round_half_away(longint'(slope) * log_gap, FRAC_BITS);
    if (idx < 0) idx = 0;
    if (idx > longint'(index_max)) idx = longint'(index_max);
    est.instant_index_q8 = idx[INDEX_W-1:0];
    est.first_reading = !avg_loaded;
    if (!avg_loaded) begin
      avg = idx[INDEX_W-1:0];
      avg_loaded = 1'b1;
    end else begin
      a = (alpha > ALPHA_ONE) ? 256 : 32'(alpha);
      d = idx - longint'(avg);
      d = longint'(avg) + round_half_away(longint'(a) * d, AVG_SHIFT);
      avg = d[INDEX_W-1:0];
    end
    est.smoothed_index_q8 = avg;
    return est;
  endfunction

  function automatic plan_row_t reading_row(logic [RES_W-1:0] ohm);
    plan_row_t row;
    row = '0;
    row.kind = ROW_READING;
    row.data = ohm;
    return row;
  endfunction

  function automatic plan_row_t checked_row(logic [RES_W-1:0] ohm, int smooth, int inst,
                                            logic first);
    plan_row_t row;
    row = reading_row(ohm);
    row.typed = 1'b1;
    row.value.smoothed_index_q8 = INDEX_W'(smooth);
    row.value.instant_index_q8 = INDEX_W'(inst);
    row.value.first_reading = first;
    return row;
  endfunction

  function automatic plan_row_t write_row(logic [CFG_INDEX_W-1:0] idx, int val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.data = CFG_DATA_W'(val);
    return row;
  endfunction

  function automatic logic [RES_W-1:0] spread_ohm();
    logic [31:0] v;
    int w;
    w = $urandom_range(1, RES_W);
    v = $urandom() & ((32'd1 << w) - 1);
    v = v | (32'd1 << (w - 1));
    return v[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] near_ohm(logic [RES_W-1:0] center);
    int t;
    t = int'(center) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > int'(OHM_TOP)) t = int'(OHM_TOP);
    return t[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] draw_ohm();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0, 1: return v[RES_W-1:0];
      2, 3, 4, 5: return spread_ohm();
      6: return near_ohm(floor_ohm);
      7: return near_ohm(ref_ohm);
      8: return RES_W'($urandom_range(0, 255));
      default: return $urandom_range(0, 1) ? OHM_TOP : '0;
    endcase
  endfunction

  task automatic report_beat(string what, result_t want, result_t got);
    if (bad_beats < 10) begin
      $display("%s: expected smoothed=%0d instant=%0d first=%0d,", what,
               want.smoothed_index_q8, want.instant_index_q8, want.first_reading);
      $display("  got smoothed=%0d instant=%0d first=%0d",
               got.smoothed_index_q8, got.instant_index_q8, got.first_reading);
    end
    bad_beats++;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    plan_row_t note;
    if (rst) begin
      ref_ohm = RST_REF_RESISTANCE;
      ref_index = RST_REF_INDEX;
      slope = RST_SLOPE;
      floor_ohm = RST_MIN_RESISTANCE;
      index_max = RST_INDEX_MAX;
      alpha = RST_ALPHA;
      avg = '0;
      avg_loaded = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REF_RESISTANCE: ref_ohm = cfg_data[RES_W-1:0];
          REG_REF_INDEX:      ref_index = cfg_data[INDEX_W-1:0];
          REG_SLOPE:          slope = cfg_data[SLOPE_W-1:0];
          REG_MIN_RESISTANCE: floor_ohm = cfg_data[RES_W-1:0];
          REG_INDEX_MAX:      index_max = cfg_data[INDEX_W-1:0];
          REG_ALPHA:          alpha = cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (reading_ch.valid && reading_ch.ready) begin
        want = estimate_aqi(reading_ch.payload.gas_resistance_ohm);
        if (sent_rows.size() != 0) begin
          note = sent_rows.pop_front();
          if (note.typed) want = note.value;
        end
        awaited_aqi.push_back(want);
      end
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        if (awaited_aqi.size() == 0) begin
          report_beat("result beat with no reading outstanding", '0, got);
        end else begin
          want = awaited_aqi.pop_front();
          if (got.smoothed_index_q8 !== want.smoothed_index_q8 ||
              got.instant_index_q8 !== want.instant_index_q8 ||
              got.first_reading !== want.first_reading) begin
            report_beat("result beat differs", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (reading_ch.valid && reading_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("gas_resistance_aqi_estimator_top: mismatch");
      $finish;
    end
  end

  // Result side: random stalls, eager stretches, and one long hold-off on request.
  initial begin
    int stall;
    int beats;
    bit sink_eager;
    bit held;
    result_ch.ready <= 1'b0;
    beats = 0;
    sink_eager = 1'b0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (beats % 32 == 0) sink_eager = ($urandom_range(0, 3) == 0);
      if (hold_request && !held) begin
        stall = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        stall = sink_eager ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      beats++;
    end
  end

  task automatic send_reading(logic [RES_W-1:0] ohm);
    int gap;
    if (src_beats % 32 == 0) src_eager = ($urandom_range(0, 3) == 0);
    src_beats++;
    gap = (src_eager || force_eager) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      reading_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    reading_ch.valid <= 1'b1;
    reading_ch.payload.gas_resistance_ohm <= ohm;
    do @(posedge clk); while (!reading_ch.ready);
  endtask

  task automatic settle();
    reading_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_aqi.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic choose_settings(int phase);
    logic [CFG_DATA_W-1:0] v_ref;
    logic [CFG_DATA_W-1:0] v_index;
    logic [CFG_DATA_W-1:0] v_slope;
    logic [CFG_DATA_W-1:0] v_floor;
    logic [CFG_DATA_W-1:0] v_max;
    logic [CFG_DATA_W-1:0] v_alpha;
    v_ref = RST_REF_RESISTANCE;
    v_index = CFG_DATA_W'(RST_REF_INDEX);
    v_slope = CFG_DATA_W'(RST_SLOPE);
    v_floor = RST_MIN_RESISTANCE;
    v_max = CFG_DATA_W'(RST_INDEX_MAX);
    v_alpha = CFG_DATA_W'(RST_ALPHA);
    if (phase != 0) begin
      v_ref = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? OHM_TOP : 24'd1)
                                          : spread_ohm();
      v_index = CFG_DATA_W'($urandom_range(0, INDEX_TOP));
      v_slope = CFG_DATA_W'(($urandom_range(0, 5) == 0) ?
                            ($urandom_range(0, 1) ? 32'(SLOPE_TOP) : 32'd0)
                            : $urandom_range(0, SLOPE_TOP));
      v_floor = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? 32'd1 : $urandom_range(1, 5000));
      v_max = CFG_DATA_W'(($urandom_range(0, 5) == 0) ?
                          ($urandom_range(0, 1) ? 32'(INDEX_TOP) : 32'd0)
                          : $urandom_range(0, INDEX_TOP));
      v_alpha = CFG_DATA_W'(($urandom_range(0, 5) == 0) ?
                            ($urandom_range(0, 1) ? 32'(ALPHA_ONE) : 32'd1)
                            : $urandom_range(1, ALPHA_ONE));
    end
    write_reg(REG_REF_RESISTANCE, v_ref);
    write_reg(REG_REF_INDEX, v_index);
    write_reg(REG_SLOPE, v_slope);
    write_reg(REG_MIN_RESISTANCE, v_floor);
    write_reg(REG_INDEX_MAX, v_max);
    write_reg(REG_ALPHA, v_alpha);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int i;
    int phase;
    int n;
    logic [RES_W-1:0] ohm;
    reading_ch.valid <= 1'b0;
    reading_ch.payload <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;

    plan = '{
      checked_row(43000, 10496, 10496, 1'b1),
      checked_row(43000, 10496, 10496, 1'b0),
      reading_row(0),
      reading_row(OHM_TOP),
      reading_row(99),
      reading_row(1),
      write_row(REG_ALPHA, ALPHA_ONE),
      write_row(REG_SLOPE, SLOPE_TOP),
      checked_row(100, INDEX_TOP, INDEX_TOP, 1'b0),
      checked_row(OHM_TOP, 0, 0, 1'b0),
      write_row(REG_ALPHA, 0),
      checked_row(100, 0, INDEX_TOP, 1'b0),
      write_row(REG_ALPHA, ALPHA_OVER),
      write_row(REG_INDEX_MAX, 0),
      checked_row(43000, 0, 0, 1'b0),
      write_row(REG_INDEX_MAX, INDEX_TOP),
      write_row(REG_SLOPE, 0),
      write_row(REG_REF_INDEX, INDEX_TOP),
      checked_row(12345, INDEX_TOP, INDEX_TOP, 1'b0),
      write_row(REG_REF_INDEX, 0),
      checked_row(7, 0, 0, 1'b0),
      write_row(REG_REF_RESISTANCE, 0),
      write_row(REG_MIN_RESISTANCE, 0),
      write_row(REG_SLOPE, RST_SLOPE),
      write_row(REG_REF_INDEX, RST_REF_INDEX),
      write_row(REG_ALPHA, RST_ALPHA),
      reading_row(0),
      reading_row(1),
      reading_row(OHM_TOP),
      write_row(REG_REF_RESISTANCE, OHM_TOP),
      write_row(REG_MIN_RESISTANCE, OHM_TOP),
      reading_row(5),
      write_row(REG_SPARE_LO, OHM_TOP),
      write_row(REG_SPARE_HI, OHM_TOP),
      reading_row(200)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (i == 0 || plan[i-1].kind != ROW_WRITE) settle();
        write_reg(plan[i].reg_idx, plan[i].data);
        if (i == plan.size() - 1 || plan[i+1].kind != ROW_WRITE) cfg_we <= 1'b0;
      end else begin
        sent_rows.push_back(plan[i]);
        send_reading(plan[i].data);
      end
    end

    // In the pressure phase the sender never idles while the result side holds off,
    // so the block fills up and must stall the reading channel.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      choose_settings(phase);
      if (phase == 3) begin
        force_eager = 1'b1;
        hold_request = 1'b1;
      end
      for (n = 0; n < PHASE_BEATS; n++) begin
        ohm = draw_ohm();
        sent_rows.push_back(reading_row(ohm));
        send_reading(ohm);
      end
      force_eager = 1'b0;
    end

    settle();
    repeat (40) @(posedge clk);
    if (awaited_aqi.size() != 0) begin
      $display("%0d result beats never arrived", awaited_aqi.size());
    end
    if (bad_beats == 0 && awaited_aqi.size() == 0) begin
      $display("gas_resistance_aqi_estimator_top: match");
    end else begin
      $display("gas_resistance_aqi_estimator_top: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/graq_pkg.sv
design/graq_reading_if.sv
design/graq_result_if.sv
design/graq_ctrl.sv
design/graq_datapath.sv
design/gas_resistance_aqi_estimator_top.sv
sim/testbench.sv
